### rtl/ffpea_pkg.sv
`timescale 1ns / 1ps
package ffpea_pkg;

   localparam int MAX_EXTENTS_DEF    = 64;
   localparam int PAGE_ADDR_BITS_DEF = 20;

   localparam logic       OP_ALLOC = 1'b0;
   localparam logic       OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_MERGE_RD,
      S_MERGE_CHK,
      S_SHIFT_DN_RD,
      S_SHIFT_DN_WR,
      S_SHIFT_UP_RD,
      S_SHIFT_UP_WR,
      S_TAIL_CHK,
      S_DONE
   } fsm_type;

   // memory access request from sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

### rtl/first_fit_page_extent_allocator_core.sv
`timescale 1ns / 1ps
// first-fit page extent allocator
// request channel (req_valid/req_ready): req_operation 0 allocates req_length_pages
// pages, 1 frees req_length_pages pages starting at req_page_offset.
// response channel (rsp_valid/rsp_ready): one transaction per request carrying
// rsp_status (0 ok, 1 no space, 2 freed extent dropped) and rsp_granted_page.
// csr channel (csr_valid/csr_ready): writes the heap limit in pages; write only
// while no request is in flight.
// free extents live in one synchronous table memory sorted by address; a
// request walks it one entry at a time (read, then check), and removing
// or inserting an entry shifts the tail one entry at a time. one request is
// worked on at a time, the next is taken the cycle after the response is taken.
// the response is held in an output register; a new request is taken once it
// has been consumed, so a stalled receiver stalls the request side.
// reset clears the extent count, the boundary and the limit to full span; the
// table needs no clearing since only entries below the count are read.
module first_fit_page_extent_allocator_core #(
   parameter int MAX_EXTENTS    = ffpea_pkg::MAX_EXTENTS_DEF,
   parameter int PAGE_ADDR_BITS = ffpea_pkg::PAGE_ADDR_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  logic [PAGE_ADDR_BITS-1:0] req_page_offset,
   input  logic [PAGE_ADDR_BITS:0]   req_length_pages,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [PAGE_ADDR_BITS-1:0] rsp_granted_page,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [PAGE_ADDR_BITS:0]   csr_heap_limit_pages
);

   localparam int AW = PAGE_ADDR_BITS;
   localparam int LW = PAGE_ADDR_BITS + 1;
   localparam int IW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam int EW = AW + LW;
   localparam logic [CW-1:0] MAXC = CW'(MAX_EXTENTS);
   localparam logic [LW:0]   SPAN = (LW+1)'(1) << AW;

   ffpea_pkg::fsm_type state_ff, state_in;
   ffpea_pkg::mem_ctl_type mctl;

   logic [LW-1:0] limit_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] bound_ff, bound_in;
   logic          op_ff, op_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [LW-1:0] size_ff, size_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] tgt_ff, tgt_in;
   logic [EW-1:0] hold_ff, hold_in;
   logic          rv_ff, rv_in;
   logic [1:0]    st_ff, st_in;
   logic [AW-1:0] gp_ff, gp_in;

   logic [IW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [AW-1:0] e_start;
   logic [LW-1:0] e_len;
   logic [LW:0]   e_end, f_end, b_sum, lim_eff;

   ffpea_ram #(.DEPTH(MAX_EXTENTS), .WIDTH(EW)) u_ram (
      .clock  (clock),
      .ctl    (mctl),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   assign e_start = rd_data[EW-1:LW];
   assign e_len   = rd_data[LW-1:0];
   assign e_end   = (LW+1)'(e_start) + (LW+1)'(e_len);
   assign f_end   = (LW+1)'(addr_ff) + (LW+1)'(size_ff);
   assign b_sum   = (LW+1)'(bound_ff) + (LW+1)'(size_ff);
   assign lim_eff = ((LW+1)'(limit_ff) > SPAN) ? SPAN : (LW+1)'(limit_ff);

   assign req_ready = (state_ff == ffpea_pkg::S_IDLE) && !rv_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_granted_page = gp_ff;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffpea_pkg::S_IDLE;
         count_ff <= '0;
         bound_ff <= '0;
         limit_ff <= LW'(SPAN);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bound_ff <= bound_in;
         rv_ff    <= rv_in;
         if (csr_valid) begin
            limit_ff <= csr_heap_limit_pages;
         end
      end
      op_ff   <= op_in;
      addr_ff <= addr_in;
      size_ff <= size_in;
      idx_ff  <= idx_in;
      tgt_ff  <= tgt_in;
      hold_ff <= hold_in;
      st_ff   <= st_in;
      gp_ff   <= gp_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      bound_in = bound_ff;
      op_in    = op_ff;
      addr_in  = addr_ff;
      size_in  = size_ff;
      idx_in   = idx_ff;
      tgt_in   = tgt_ff;
      hold_in  = hold_ff;
      rv_in    = rv_ff;
      st_in    = st_ff;
      gp_in    = gp_ff;
      mctl     = '0;
      rd_addr  = idx_ff[IW-1:0];
      wr_addr  = idx_ff[IW-1:0];
      wr_data  = hold_ff;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         ffpea_pkg::S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in   = req_operation;
               addr_in = req_page_offset;
               size_in = req_length_pages;
               idx_in  = '0;
               st_in   = ffpea_pkg::ST_OK;
               gp_in   = '0;
               state_in = ffpea_pkg::S_SCAN_RD;
            end
         end
         ffpea_pkg::S_SCAN_RD: begin
            if (op_ff == ffpea_pkg::OP_ALLOC) begin
               if (size_ff == '0) begin
                  st_in = ffpea_pkg::ST_NOSPACE;
                  state_in = ffpea_pkg::S_DONE;
               end else if (idx_ff < count_ff) begin
                  mctl.rd_en = 1'b1;
                  state_in = ffpea_pkg::S_SCAN_CHK;
               end else if (b_sum <= lim_eff) begin
                  gp_in = bound_ff[AW-1:0];
                  bound_in = b_sum[LW-1:0];
                  state_in = ffpea_pkg::S_DONE;
               end else begin
                  st_in = ffpea_pkg::ST_NOSPACE;
                  state_in = ffpea_pkg::S_DONE;
               end
            end else begin
               if (size_ff == '0 || f_end > (LW+1)'(bound_ff)) begin
                  state_in = ffpea_pkg::S_DONE;
               end else if (f_end == (LW+1)'(bound_ff)) begin
                  bound_in = LW'(addr_ff);
                  if (count_ff != '0) begin
                     idx_in = count_ff - CW'(1);
                     rd_addr = IW'(count_ff - CW'(1));
                     mctl.rd_en = 1'b1;
                     state_in = ffpea_pkg::S_TAIL_CHK;
                  end else begin
                     state_in = ffpea_pkg::S_DONE;
                  end
               end else if (idx_ff < count_ff) begin
                  mctl.rd_en = 1'b1;
                  state_in = ffpea_pkg::S_SCAN_CHK;
               end else begin
                  // insert at end of table
                  tgt_in = idx_ff;
                  if (count_ff >= MAXC) begin
                     st_in = ffpea_pkg::ST_DROPPED;
                     state_in = ffpea_pkg::S_DONE;
                  end else begin
                     wr_data = {addr_ff, size_ff};
                     mctl.wr_en = 1'b1;
                     count_in = count_ff + CW'(1);
                     state_in = ffpea_pkg::S_DONE;
                  end
               end
            end
         end
         ffpea_pkg::S_SCAN_CHK: begin
            if (op_ff == ffpea_pkg::OP_ALLOC) begin
               if (e_len >= size_ff) begin
                  gp_in = e_start;
                  if (e_len == size_ff) begin
                     idx_in = idx_ff + CW'(1);
                     state_in = ffpea_pkg::S_SHIFT_DN_RD;
                  end else begin
                     wr_data = {AW'((LW+1)'(e_start) + (LW+1)'(size_ff)), e_len - size_ff};
                     mctl.wr_en = 1'b1;
                     state_in = ffpea_pkg::S_DONE;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1);
                  state_in = ffpea_pkg::S_SCAN_RD;
               end
            end else begin
               if (e_end == (LW+1)'(addr_ff)) begin
                  hold_in = {e_start, e_len + size_ff};
                  wr_data = {e_start, e_len + size_ff};
                  mctl.wr_en = 1'b1;
                  if (idx_ff + CW'(1) < count_ff) begin
                     tgt_in = idx_ff;
                     idx_in = idx_ff + CW'(1);
                     rd_addr = IW'(idx_ff + CW'(1));
                     mctl.rd_en = 1'b1;
                     state_in = ffpea_pkg::S_MERGE_CHK;
                  end else begin
                     state_in = ffpea_pkg::S_DONE;
                  end
               end else if ((LW+1)'(e_start) == f_end) begin
                  wr_data = {addr_ff, e_len + size_ff};
                  mctl.wr_en = 1'b1;
                  state_in = ffpea_pkg::S_DONE;
               end else if (e_start > addr_ff) begin
                  if (count_ff >= MAXC) begin
                     st_in = ffpea_pkg::ST_DROPPED;
                     state_in = ffpea_pkg::S_DONE;
                  end else begin
                     tgt_in = idx_ff;
                     idx_in = count_ff;
                     count_in = count_ff + CW'(1);
                     state_in = ffpea_pkg::S_SHIFT_UP_RD;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1);
                  state_in = ffpea_pkg::S_SCAN_RD;
               end
            end
         end
         ffpea_pkg::S_MERGE_RD: begin
            state_in = ffpea_pkg::S_MERGE_CHK;
         end
         ffpea_pkg::S_MERGE_CHK: begin
            // next extent starts where the freed one ends: absorb and close gap
            if ((LW+1)'(e_start) == f_end) begin
               wr_addr = tgt_ff[IW-1:0];
               wr_data = {hold_ff[EW-1:LW], hold_ff[LW-1:0] + e_len};
               mctl.wr_en = 1'b1;
               idx_in = idx_ff + CW'(1);
               state_in = ffpea_pkg::S_SHIFT_DN_RD;
            end else begin
               state_in = ffpea_pkg::S_DONE;
            end
         end
         ffpea_pkg::S_SHIFT_DN_RD: begin
            // idx points at source entry; move it down by one
            if (idx_ff < count_ff) begin
               mctl.rd_en = 1'b1;
               state_in = ffpea_pkg::S_SHIFT_DN_WR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ffpea_pkg::S_DONE;
            end
         end
         ffpea_pkg::S_SHIFT_DN_WR: begin
            wr_addr = IW'(idx_ff - CW'(1));
            wr_data = rd_data;
            mctl.wr_en = 1'b1;
            idx_in = idx_ff + CW'(1);
            state_in = ffpea_pkg::S_SHIFT_DN_RD;
         end
         ffpea_pkg::S_SHIFT_UP_RD: begin
            // idx points at destination; copy idx-1 up, then place new entry
            if (idx_ff > tgt_ff) begin
               rd_addr = IW'(idx_ff - CW'(1));
               mctl.rd_en = 1'b1;
               state_in = ffpea_pkg::S_SHIFT_UP_WR;
            end else begin
               wr_data = {addr_ff, size_ff};
               mctl.wr_en = 1'b1;
               state_in = ffpea_pkg::S_DONE;
            end
         end
         ffpea_pkg::S_SHIFT_UP_WR: begin
            wr_data = rd_data;
            mctl.wr_en = 1'b1;
            idx_in = idx_ff - CW'(1);
            state_in = ffpea_pkg::S_SHIFT_UP_RD;
         end
         ffpea_pkg::S_TAIL_CHK: begin
            if (e_end == (LW+1)'(bound_ff)) begin
               bound_in = LW'(e_start);
               count_in = count_ff - CW'(1);
            end
            state_in = ffpea_pkg::S_DONE;
         end
         ffpea_pkg::S_DONE: begin
            rv_in = 1'b1;
            state_in = ffpea_pkg::S_IDLE;
         end
         default: begin
            state_in = ffpea_pkg::S_IDLE;
         end
      endcase
   end

endmodule

### rtl/ffpea_ram.sv
`timescale 1ns / 1ps
module ffpea_ram #(
   parameter int DEPTH = ffpea_pkg::MAX_EXTENTS_DEF,
   parameter int WIDTH = 41
) (
   input  logic                     clock,
   input  ffpea_pkg::mem_ctl_type   ctl,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write, single registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/alloc_checker.sv
`timescale 1ns / 1ps
module alloc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_operation,
   input  logic [19:0] req_page_offset,
   input  logic [20:0] req_length_pages,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [19:0] rsp_granted_page,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [20:0] csr_heap_limit_pages,
   output int          fail_count,
   output int          pending_count,
   output int          free_count,
   output int          boundary_now
);

   localparam int          NSLOT = ffpea_pkg::MAX_EXTENTS_DEF;
   localparam logic [21:0] SPAN  = 22'd1 << 20;
   localparam logic [21:0] LMASK = 22'h1fffff;

   typedef struct packed {
      logic [1:0]  status;
      logic [19:0] page;
   } grant_t;

   // shadow heap state
   logic [21:0] free_start [NSLOT];
   logic [21:0] free_len [NSLOT];
   int          free_num;
   logic [21:0] boundary;
   logic [21:0] limit_pages;
   grant_t      grant_q [$];
   int          mismatch_count;

   function automatic void drop_slot(int idx);
      for (int k = idx; k + 1 < free_num; k++) begin
         free_start[k] = free_start[k + 1];
         free_len[k]   = free_len[k + 1];
      end
      free_num--;
   endfunction

   function automatic grant_t allocate_pages(logic [21:0] size);
      grant_t      g;
      logic [21:0] lim;
      g   = '{ffpea_pkg::ST_NOSPACE, 20'd0};
      lim = (limit_pages > SPAN) ? SPAN : limit_pages;
      if (size == 0) return g;
      for (int i = 0; i < free_num; i++) begin
         if (free_len[i] >= size) begin
            g = '{ffpea_pkg::ST_OK, free_start[i][19:0]};
            if (free_len[i] == size) drop_slot(i);
            else begin
               free_start[i] = (free_start[i] + size) & (SPAN - 1);
               free_len[i]   = free_len[i] - size;
            end
            return g;
         end
      end
      if (boundary + size <= lim) begin
         g = '{ffpea_pkg::ST_OK, boundary[19:0]};
         boundary = boundary + size;
      end
      return g;
   endfunction

   function automatic grant_t free_pages(logic [21:0] addr, logic [21:0] size);
      logic [21:0] fin;
      int          i;
      fin = addr + size;
      if (size == 0 || fin > boundary) return '{ffpea_pkg::ST_OK, 20'd0};
      if (fin == boundary) begin
         boundary = addr;
         if (free_num > 0 &&
             free_start[free_num - 1] + free_len[free_num - 1] == boundary) begin
            boundary = free_start[free_num - 1];
            free_num--;
         end
         return '{ffpea_pkg::ST_OK, 20'd0};
      end
      for (i = 0; i < free_num; i++) begin
         if (free_start[i] + free_len[i] == addr) begin
            free_len[i] = (free_len[i] + size) & LMASK;
            if (i + 1 < free_num && free_start[i + 1] == fin) begin
               free_len[i] = (free_len[i] + free_len[i + 1]) & LMASK;
               drop_slot(i + 1);
            end
            return '{ffpea_pkg::ST_OK, 20'd0};
         end
         if (free_start[i] == fin) begin
            free_start[i] = addr;
            free_len[i]   = (free_len[i] + size) & LMASK;
            return '{ffpea_pkg::ST_OK, 20'd0};
         end
         if (free_start[i] > addr) break;
      end
      if (free_num >= NSLOT) return '{ffpea_pkg::ST_DROPPED, 20'd0};
      for (int k = free_num; k > i; k--) begin
         free_start[k] = free_start[k - 1];
         free_len[k]   = free_len[k - 1];
      end
      free_start[i] = addr;
      free_len[i]   = size;
      free_num++;
      return '{ffpea_pkg::ST_OK, 20'd0};
   endfunction

   assign pending_count = grant_q.size();
   assign free_count    = free_num;
   assign boundary_now  = boundary;
   assign fail_count    = mismatch_count;

   // observe transactions and compare
   always @(posedge clock) begin
      grant_t g;
      grant_t seen;
      if (reset) begin
         free_num       = 0;
         boundary       = '0;
         limit_pages    = SPAN;
         grant_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) limit_pages = {1'b0, csr_heap_limit_pages};
         if (req_valid && req_ready) begin
            if (req_operation == ffpea_pkg::OP_ALLOC)
               g = allocate_pages({1'b0, req_length_pages});
            else g = free_pages({2'b0, req_page_offset}, {1'b0, req_length_pages});
            grant_q.push_back(g);
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_status, rsp_granted_page};
            if (grant_q.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("unexpected response status=%0d page=%0d",
                     rsp_status, rsp_granted_page);
            end else begin
               g = grant_q.pop_front();
               if (g != seen) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp status=%0d page=%0d, got status=%0d page=%0d",
                        g.status, g.page, rsp_status, rsp_granted_page);
               end
            end
         end
      end
   end
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready, req_operation;
   logic [19:0] req_page_offset;
   logic [20:0] req_length_pages;
   logic        rsp_valid, rsp_ready;
   logic [1:0]  rsp_status;
   logic [19:0] rsp_granted_page;
   logic        csr_valid, csr_ready;
   logic [20:0] csr_heap_limit_pages;
   int          fail_count, pending_count, free_count, boundary_now;
   int          send_idle_pct, recv_stall_pct;
   int          hold_off;
   logic        long_stall_req, long_stall_done;
   int          quiet_cycles;
   int          req_sent;

   first_fit_page_extent_allocator_core u_top (.*);

   alloc_checker u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response side stalls, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready       <= 1'b0;
         hold_off        <= 0;
         long_stall_done <= 1'b0;
      end else if (long_stall_req && !long_stall_done) begin
         rsp_ready       <= 1'b0;
         hold_off        <= 400;
         long_stall_done <= 1'b1;
      end else if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off  <= hold_off - 1;
      end else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("first_fit_page_extent_allocator_core regression: fail");
         $finish;
      end
   end

   task automatic send_request(logic op, logic [19:0] offs, logic [20:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_page_offset  <= offs;
      req_length_pages <= len;
      do @(posedge clock); while (!req_ready);
      req_sent++;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_limit(logic [20:0] lim);
      drain_all();
      csr_valid            <= 1'b1;
      csr_heap_limit_pages <= lim;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // small random lengths mostly, with occasional huge and zero ones
   function automatic logic [20:0] pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 21'($urandom_range(16, 1));
      if (r < 90) return 21'($urandom_range(300, 1));
      if (r < 97) return 21'($urandom_range(21'h1fffff));
      return 21'd0;
   endfunction

   // random allocs and frees; frees mostly hit pieces inside the used region, often fragmenting the table
   task automatic random_phase(int count);
      logic [19:0] offs;
      logic [20:0] len;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 55)
            send_request(ffpea_pkg::OP_ALLOC, 20'($urandom), pick_len());
         else begin
            len = pick_len();
            if (boundary_now > 0 && $urandom_range(99) < 85) begin
               offs = 20'($urandom_range(boundary_now - 1));
               if ($urandom_range(3) == 0) len = 21'(boundary_now - offs);
               else if (len > boundary_now - offs) len = 21'($urandom_range(4, 1));
            end else offs = 20'($urandom);
            send_request(ffpea_pkg::OP_FREE, offs, len);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_operation = 1'b0;
      req_page_offset = '0; req_length_pages = '0;
      csr_valid = 1'b0; csr_heap_limit_pages = '0;
      send_idle_pct = 0; recv_stall_pct = 0; long_stall_req = 1'b0; req_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: edge lengths, boundary frees, coalescing, overflow
      send_request(ffpea_pkg::OP_ALLOC, 20'hfffff, 21'd0);
      send_request(ffpea_pkg::OP_ALLOC, 20'd0, 21'd4);
      send_request(ffpea_pkg::OP_ALLOC, 20'd0, 21'd8);
      send_request(ffpea_pkg::OP_ALLOC, 20'd0, 21'd2);
      send_request(ffpea_pkg::OP_FREE, 20'd0, 21'd0);
      send_request(ffpea_pkg::OP_FREE, 20'd100, 21'd4);
      send_request(ffpea_pkg::OP_FREE, 20'd0, 21'd2);
      send_request(ffpea_pkg::OP_FREE, 20'd4, 21'd2);
      send_request(ffpea_pkg::OP_FREE, 20'd2, 21'd2);
      send_request(ffpea_pkg::OP_FREE, 20'd12, 21'd2);
      send_request(ffpea_pkg::OP_ALLOC, 20'd0, 21'd3);
      send_request(ffpea_pkg::OP_ALLOC, 20'd0, 21'h100000);
      send_request(ffpea_pkg::OP_ALLOC, 20'd0, 21'h1fffff);
      send_request(ffpea_pkg::OP_FREE, 20'hfffff, 21'h1fffff);
      write_limit(21'd0);
      send_request(ffpea_pkg::OP_ALLOC, 20'd0, 21'd200);
      write_limit(21'h1fffff);
      send_request(ffpea_pkg::OP_ALLOC, 20'd0, 21'h0ffff0);
      send_request(ffpea_pkg::OP_ALLOC, 20'd0, 21'd32);
      write_limit(21'd1);

      // fill the table past capacity with one-page holes
      write_limit(21'h100000);
      for (int k = 0; k < 70; k++) send_request(ffpea_pkg::OP_ALLOC, 20'd0, 21'd2);
      for (int k = 0; k < 70; k++)
         send_request(ffpea_pkg::OP_FREE, 20'(2 * k + 16), 21'd1);

      // random phases with varying idling and limits
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         if (ph == 4) write_limit(21'd1);
         else if (ph == 5) write_limit(21'($urandom_range(4000, 500)));
         else if (ph == 6) write_limit(21'h100000);
         if (ph == 2) long_stall_req <= 1'b1;
         random_phase(230);
         if (ph == 3) drain_all();
      end

      drain_all();
      $display("covered %0d requests over four idling mixes and five heap limits;",
         req_sent);
      $display("final table holds %0d free extents, boundary %0d", free_count,
         boundary_now);
      if (fail_count == 0)
         $display("first_fit_page_extent_allocator_core regression: pass");
      else
         $display("first_fit_page_extent_allocator_core regression: fail");
      $finish;
   end
endmodule

### sim.f
rtl/ffpea_pkg.sv
rtl/ffpea_ram.sv
rtl/first_fit_page_extent_allocator_core.sv
tb/alloc_checker.sv
tb/tb.sv
